/* sv/itda_pkg.sv */
package itda_pkg;

    // default configuration
    localparam int VALUE_WIDTH_DEF    = 64;
    localparam int MAX_MIN_DIGITS_DEF = 32;

    // character codes
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic neg;
        logic idx_zero;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/itda_dpath.sv */
module itda_dpath #(
    parameter int VALUE_WIDTH    = itda_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_MIN_DIGITS = itda_pkg::MAX_MIN_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [63:0]            i_value_bits,
    input  logic                   i_is_signed,
    input  logic [5:0]             i_min_digits,
    input  logic                   i_out_ready,
    input  itda_pkg::t_dp_cmd      i_cmd,
    output itda_pkg::t_dp_sts      o_sts,
    output logic                   o_out_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_last_char
);

    // decimal digits needed for the widest unsigned value
    localparam int NumDig = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int DigIW  = $clog2(NumDig);
    localparam int TotMax = (NumDig > MAX_MIN_DIGITS) ? NumDig : MAX_MIN_DIGITS;
    localparam int CW     = $clog2(TotMax + 1);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [3:0]             r_bcd [NumDig];
    logic [3:0]             n_bcd [NumDig];
    logic                   r_neg;
    logic [CW-1:0]          r_min;
    logic [CW-1:0]          r_idx;
    logic                   r_out_valid;
    logic [7:0]             r_char_code;
    logic                   r_last_char;

    logic [VALUE_WIDTH-1:0] in_val;
    logic                   in_neg;
    logic [5:0]             min_sat;
    logic [CW-1:0]          natural;
    logic [CW-1:0]          total;
    logic [3:0]             cur_digit;

    // sign and magnitude of the incoming item
    assign in_val  = i_value_bits[VALUE_WIDTH-1:0];
    assign in_neg  = i_is_signed & in_val[VALUE_WIDTH-1];
    assign min_sat = (i_min_digits > 6'(MAX_MIN_DIGITS)) ? 6'(MAX_MIN_DIGITS) : i_min_digits;

    // one shift-add-3 step over all digits
    always_comb begin
        for (int k = 0; k < NumDig; k++) begin
            logic [3:0] adj;
            logic       low_in;
            adj = (r_bcd[k] >= 4'd5) ? (r_bcd[k] + 4'd3) : r_bcd[k];
            if (k == 0) begin
                low_in = r_mag[VALUE_WIDTH-1];
            end else begin
                low_in = (r_bcd[k-1] >= 4'd5) ? 1'b1 : r_bcd[k-1][3];
            end
            n_bcd[k] = {adj[2:0], low_in};
        end
    end

    // natural digit count, at least one
    always_comb begin
        natural = CW'(1);
        for (int k = 1; k < NumDig; k++) begin
            if (r_bcd[k] != 4'd0) begin
                natural = CW'(k + 1);
            end
        end
        total = (r_min > natural) ? r_min : natural;
    end

    // digit at the current position, zero beyond the converted digits
    assign cur_digit = (r_idx < CW'(NumDig)) ? r_bcd[r_idx[DigIW-1:0]] : 4'd0;

    // conversion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
            r_neg <= in_neg;
            r_min <= CW'(min_sat);
            for (int k = 0; k < NumDig; k++) begin
                r_bcd[k] <= 4'd0;
            end
        end else if (i_cmd.shift) begin
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            for (int k = 0; k < NumDig; k++) begin
                r_bcd[k] <= n_bcd[k];
            end
        end
    end

    // character position counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_idx <= total - CW'(1);
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char_code <= itda_pkg::CHAR_MINUS;
            r_last_char <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char_code <= itda_pkg::CHAR_ZERO + {4'd0, cur_digit};
            r_last_char <= (r_idx == CW'(0));
        end
    end

    assign o_sts.neg      = r_neg;
    assign o_sts.idx_zero = (r_idx == CW'(0));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char_code;
    assign o_last_char = r_last_char;

endmodule

/* sv/itda_ctrl.sv */
module itda_ctrl #(
    parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  itda_pkg::t_dp_sts  i_sts,
    output itda_pkg::t_dp_cmd  o_cmd
);

    localparam int CntW = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + CntW'(1);
                if (r_cnt == CntW'(VALUE_WIDTH - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* sv/int_to_decimal_ascii_top.sv */
// Formats a VALUE_WIDTH-bit integer (signed or unsigned) as decimal ASCII text, one
// character per output item, most significant first, with o_last_char set on the final
// one. A negative signed value starts with '-', and leading zeros pad the digits after
// the sign up to i_min_digits (saturated at MAX_MIN_DIGITS, 0 for no padding). One item
// is worked at a time: a shift-add-3 binary to BCD converter takes one bit per cycle, then
// each character waits while the sink holds o_out_valid without i_out_ready. The next
// item is accepted in the cycle after the last character has been loaded into the
// output register.
module int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH    = itda_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_MIN_DIGITS = itda_pkg::MAX_MIN_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_value_bits,
    input  logic        i_is_signed,
    input  logic [5:0]  i_min_digits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);

    itda_pkg::t_dp_cmd cmd;
    itda_pkg::t_dp_sts sts;

    // sequencer
    itda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // converter and character output
    itda_dpath #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .MAX_MIN_DIGITS (MAX_MIN_DIGITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value_bits (i_value_bits),
        .i_is_signed  (i_is_signed),
        .i_min_digits (i_min_digits),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

    // only minus or decimal digits leave the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_code == itda_pkg::CHAR_MINUS) ||
                        ((o_char_code >= itda_pkg::CHAR_ZERO) &&
                         (o_char_code <= itda_pkg::CHAR_ZERO + 8'd9)))
        else $error("character code out of range");

    // the sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_char_code == itda_pkg::CHAR_MINUS)) |-> !o_last_char)
        else $error("minus marked as last character");

    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an accepted item");

    // no character appears during conversion right after accept
    a_no_early_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (!o_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("character emitted before conversion finished");

endmodule
